// ===== rtl/core/per_cell_moving_average_assert.svh =====
// Assertion macros used by the checker file of the per-cell moving average block.
`ifndef PER_CELL_MOVING_AVERAGE_ASSERT_SVH
`define PER_CELL_MOVING_AVERAGE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCMA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle assertion failed.");

// The consequent must hold in the cycle after the antecedent.
`define PCMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle assertion failed.");

`endif

// ===== rtl/core/pcma_pkg.sv =====
// Package with the sizes, types and reciprocal table of the per-cell moving average block.
package pcma_pkg;

    localparam int CELLS   = 32;
    localparam int DEPTH   = 4;
    localparam int CELL_W  = 5;
    localparam int DATA_W  = 24;
    localparam int CIDX_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int HELD_W  = $clog2(DEPTH + 1);
    localparam int LOG_D   = $clog2(DEPTH);
    localparam int SUM_W   = DATA_W + LOG_D;
    localparam int MAG_W   = SUM_W;
    localparam int SHIFT   = MAG_W + LOG_D;
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam int ADDR_W  = $clog2(CELLS * DEPTH);

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic              accept;
        logic [ADDR_W-1:0] rd_addr;
        logic              update;
        logic [ADDR_W-1:0] wr_addr;
        logic [CIDX_W-1:0] cidx;
        logic              in_range;
        logic              full;
        logic [HELD_W-1:0] divisor;
    } lane_ctrl_t;

    typedef logic [RECIP_W-1:0] recip_table_t [DEPTH+1];

    // Entry d holds ceil(2^SHIFT / d), so that (n * entry) >> SHIFT equals n / d
    // for every magnitude n below 2^MAG_W.
    function automatic recip_table_t build_recip_table();
        recip_table_t       tbl;
        logic [RECIP_W:0]   num;
        logic [RECIP_W:0]   rem;
        logic [RECIP_W-1:0] quo;
        tbl[0] = '0;
        for (int d = 1; d <= DEPTH; d++) begin
            num = (RECIP_W + 1)'(1) << SHIFT;
            num = num + (RECIP_W + 1)'(d - 1);
            rem = '0;
            quo = '0;
            for (int b = RECIP_W; b >= 0; b--) begin
                rem = {rem[RECIP_W-1:0], num[b]};
                if (rem >= (RECIP_W + 1)'(d))
                begin
                    rem = rem - (RECIP_W + 1)'(d);
                    if (b < RECIP_W)
                    begin
                        quo[b] = 1'b1;
                    end
                end
            end
            tbl[d] = quo;
        end
        return tbl;
    endfunction

    localparam recip_table_t RECIP_TABLE = build_recip_table();

endpackage

// ===== rtl/core/pcma_ctrl.sv =====
// Sequencer with the per-cell ring position and fill count shared by both lanes.
module pcma_ctrl
    import pcma_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  logic [CELL_W-1:0] cell_index,
    input  logic              div_advance,
    output lane_ctrl_t        lane_ctrl,
    output logic              div_valid,
    output logic [CELL_W-1:0] div_cell
);

    state_t              state_reg;
    state_t              state_next;
    logic [CELL_W-1:0]   cell_reg;
    logic [CIDX_W-1:0]   cidx_reg;
    logic                in_range_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [SLOT_W-1:0]   slot_reg [CELLS];
    logic [HELD_W-1:0]   held_reg [CELLS];
    logic                div_valid_reg;
    logic                div_valid_next;
    logic [CELL_W-1:0]   div_cell_reg;

    logic                accept;
    logic                update;
    logic                in_range_in;
    logic [CIDX_W-1:0]   cidx_in;
    logic [ADDR_W-1:0]   rd_addr;
    logic [SLOT_W-1:0]   slot_cur;
    logic [HELD_W-1:0]   held_cur;
    logic                full;
    logic [HELD_W-1:0]   divisor;

    always_comb
    begin
        in_range_in = (32'(cell_index) < 32'(CELLS));
        cidx_in     = in_range_in ? CIDX_W'(cell_index) : '0;
        rd_addr     = ADDR_W'(cidx_in) * ADDR_W'(DEPTH) + ADDR_W'(slot_reg[cidx_in]);
        slot_cur    = slot_reg[cidx_reg];
        held_cur    = held_reg[cidx_reg];
        full        = (held_cur >= HELD_W'(DEPTH));
        divisor     = full ? HELD_W'(DEPTH) : held_cur + HELD_W'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!div_valid_reg || div_advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sample_ready = 1'b0;
        update       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
            end
            ST_UPDATE:
            begin
                update = !div_valid_reg || div_advance;
            end
            default:
            begin
                sample_ready = 1'b0;
            end
        endcase
        accept = sample_valid && sample_ready;
    end

    always_comb
    begin
        div_valid_next = div_valid_reg;
        if (update)
        begin
            div_valid_next = 1'b1;
        end
        else if (div_advance)
        begin
            div_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_valid_reg <= 1'b0;
            for (int i = 0; i < CELLS; i++) begin
                slot_reg[i] <= '0;
                held_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            div_valid_reg <= div_valid_next;
            if (update && in_range_reg)
            begin
                slot_reg[cidx_reg] <= (slot_cur == SLOT_W'(DEPTH - 1)) ?
                                      '0 : slot_cur + SLOT_W'(1);
                held_reg[cidx_reg] <= divisor;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cell_reg     <= cell_index;
            cidx_reg     <= cidx_in;
            in_range_reg <= in_range_in;
            addr_reg     <= rd_addr;
        end
        if (update)
        begin
            div_cell_reg <= cell_reg;
        end
    end

    always_comb
    begin
        lane_ctrl.accept   = accept;
        lane_ctrl.rd_addr  = rd_addr;
        lane_ctrl.update   = update;
        lane_ctrl.wr_addr  = addr_reg;
        lane_ctrl.cidx     = cidx_reg;
        lane_ctrl.in_range = in_range_reg;
        lane_ctrl.full     = full;
        lane_ctrl.divisor  = divisor;
    end

    assign div_valid = div_valid_reg;
    assign div_cell  = div_cell_reg;

endmodule

// ===== rtl/core/pcma_lane.sv =====
// One averaging lane: sample history memory, running totals and reciprocal divider.
module pcma_lane
    import pcma_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lane_ctrl_t               lane_ctrl,
    input  logic signed [DATA_W-1:0] sample,
    output logic signed [DATA_W-1:0] average
);

    logic [DATA_W-1:0]        hist_mem [CELLS*DEPTH];
    logic [DATA_W-1:0]        old_reg;
    logic signed [DATA_W-1:0] sample_reg;
    logic signed [SUM_W-1:0]  total_reg [CELLS];
    logic [MAG_W-1:0]         mag_reg;
    logic                     neg_reg;
    logic [RECIP_W-1:0]       recip_reg;

    logic signed [SUM_W-1:0]  total_next;
    logic signed [SUM_W-1:0]  drop;
    logic [MAG_W-1:0]         mag_next;
    logic [PROD_W-1:0]        product;
    logic [DATA_W-1:0]        quotient;

    always_comb
    begin
        drop       = lane_ctrl.full ? SUM_W'(signed'(old_reg)) : '0;
        total_next = total_reg[lane_ctrl.cidx] - drop + SUM_W'(sample_reg);
        mag_next   = total_next[SUM_W-1] ? MAG_W'(-total_next) : MAG_W'(total_next);
    end

    always_ff @(posedge clk)
    begin
        if (lane_ctrl.accept)
        begin
            old_reg    <= hist_mem[lane_ctrl.rd_addr];
            sample_reg <= sample;
        end
        if (lane_ctrl.update && lane_ctrl.in_range)
        begin
            hist_mem[lane_ctrl.wr_addr] <= sample_reg;
        end
        if (lane_ctrl.update)
        begin
            mag_reg   <= lane_ctrl.in_range ? mag_next : '0;
            neg_reg   <= lane_ctrl.in_range && total_next[SUM_W-1];
            recip_reg <= RECIP_TABLE[lane_ctrl.divisor];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++) begin
                total_reg[i] <= '0;
            end
        end
        else if (lane_ctrl.update && lane_ctrl.in_range)
        begin
            total_reg[lane_ctrl.cidx] <= total_next;
        end
    end

    always_comb
    begin
        product  = PROD_W'(mag_reg) * PROD_W'(recip_reg);
        quotient = product[SHIFT +: DATA_W];
        average  = neg_reg ? -signed'(quotient) : signed'(quotient);
    end

endmodule

// ===== rtl/core/pcma_merge.sv =====
// Output stage that joins the two lane averages with the cell index into one transaction.
module pcma_merge
    import pcma_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     div_valid,
    input  logic [CELL_W-1:0]        div_cell,
    input  logic signed [DATA_W-1:0] voltage_lane,
    input  logic signed [DATA_W-1:0] impedance_lane,
    output logic                     div_advance,
    output logic                     average_valid,
    input  logic                     average_ready,
    output logic [CELL_W-1:0]        cell_out,
    output logic signed [DATA_W-1:0] voltage_average,
    output logic signed [DATA_W-1:0] impedance_average
);

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [CELL_W-1:0]        cell_reg;
    logic signed [DATA_W-1:0] voltage_reg;
    logic signed [DATA_W-1:0] impedance_reg;

    always_comb
    begin
        div_advance    = div_valid && (!out_valid_reg || average_ready);
        out_valid_next = out_valid_reg;
        if (div_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (average_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_advance)
        begin
            cell_reg      <= div_cell;
            voltage_reg   <= voltage_lane;
            impedance_reg <= impedance_lane;
        end
    end

    assign average_valid     = out_valid_reg;
    assign cell_out          = cell_reg;
    assign voltage_average   = voltage_reg;
    assign impedance_average = impedance_reg;

endmodule

// ===== rtl/core/per_cell_moving_average.sv =====
// A result passes from the accepted sample through the divider registers to the output
// register. One sample transaction is taken at a time: the history memory is read in
// the accept cycle; ring, totals and counters are written back when the divider is free.
// Reset is asynchronous and active low; it clears the per-cell ring positions, fill
// counts and running totals, empties the divider and output stages, and is ready at once.
module per_cell_moving_average
    import pcma_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     sample_valid,
    output logic                     sample_ready,
    input  logic [CELL_W-1:0]        cell_index,
    input  logic signed [DATA_W-1:0] voltage_sample,
    input  logic signed [DATA_W-1:0] impedance_sample,
    output logic                     average_valid,
    input  logic                     average_ready,
    output logic [CELL_W-1:0]        cell_out,
    output logic signed [DATA_W-1:0] voltage_average,
    output logic signed [DATA_W-1:0] impedance_average
);

    lane_ctrl_t               lane_ctrl;
    logic                     div_valid;
    logic                     div_advance;
    logic [CELL_W-1:0]        div_cell;
    logic signed [DATA_W-1:0] voltage_lane;
    logic signed [DATA_W-1:0] impedance_lane;

    pcma_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .cell_index   (cell_index),
        .div_advance  (div_advance),
        .lane_ctrl    (lane_ctrl),
        .div_valid    (div_valid),
        .div_cell     (div_cell)
    );

    pcma_lane u_voltage_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_ctrl (lane_ctrl),
        .sample    (voltage_sample),
        .average   (voltage_lane)
    );

    pcma_lane u_impedance_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_ctrl (lane_ctrl),
        .sample    (impedance_sample),
        .average   (impedance_lane)
    );

    pcma_merge u_merge (
        .clk               (clk),
        .rst_n             (rst_n),
        .div_valid         (div_valid),
        .div_cell          (div_cell),
        .voltage_lane      (voltage_lane),
        .impedance_lane    (impedance_lane),
        .div_advance       (div_advance),
        .average_valid     (average_valid),
        .average_ready     (average_ready),
        .cell_out          (cell_out),
        .voltage_average   (voltage_average),
        .impedance_average (impedance_average)
    );

endmodule

// ===== rtl/core/pcma_checker.sv =====
// Port-level checker for the per-cell moving average block and its bind statement.
`include "per_cell_moving_average_assert.svh"

module pcma_checker
    import pcma_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     sample_valid,
    input logic                     sample_ready,
    input logic                     average_valid,
    input logic                     average_ready,
    input logic [CELL_W-1:0]        cell_out,
    input logic signed [DATA_W-1:0] voltage_average,
    input logic signed [DATA_W-1:0] impedance_average
);

    logic                       sample_accept;
    logic                       accept_out_empty;
    logic                       result_stall;
    logic [CELL_W+2*DATA_W-1:0] result_word;

    assign sample_accept    = sample_valid && sample_ready;
    assign accept_out_empty = sample_accept && !average_valid;
    assign result_stall     = average_valid && !average_ready;
    assign result_word      = {cell_out, voltage_average, impedance_average};

    // The block works on one transaction at a time and is busy in the cycle after accepting.
    `PCMA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, sample_accept, !sample_ready)

    // Ready only drops as a result of an accepted transaction.
    `PCMA_ASSERT_SAME(a_ready_drop_cause, clk, rst_n, $fell(sample_ready), $past(sample_accept))

    // With the output empty, the accepted sample's result passes the divider registers and is then shown.
    `PCMA_ASSERT_NEXT(a_result_latency, clk, rst_n, accept_out_empty, ##2 average_valid)

    // A stalled result keeps its cell index and both averages.
    `PCMA_ASSERT_NEXT(a_result_hold, clk, rst_n, result_stall, average_valid && $stable(result_word))

endmodule

bind per_cell_moving_average pcma_checker u_pcma_checker (.*);

// ===== verif/pcma_average_checker.sv =====
// Predicts and checks the averages returned by the per-cell moving average block.
`timescale 1ns / 1ps

module pcma_average_checker
    import pcma_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     sample_valid,
    input  logic                     sample_ready,
    input  logic [CELL_W-1:0]        cell_index,
    input  logic signed [DATA_W-1:0] voltage_sample,
    input  logic signed [DATA_W-1:0] impedance_sample,
    input  logic                     average_valid,
    input  logic                     average_ready,
    input  logic [CELL_W-1:0]        cell_out,
    input  logic signed [DATA_W-1:0] voltage_average,
    input  logic signed [DATA_W-1:0] impedance_average,
    output int                       mismatches,
    output int                       outstanding,
    output int                       averages_checked
);

    typedef struct packed {
        logic [CELL_W-1:0]        cell_id;
        logic signed [DATA_W-1:0] volt;
        logic signed [DATA_W-1:0] imp;
    } average_t;

    logic signed [DATA_W-1:0] volt_ring [CELLS][DEPTH];
    logic signed [DATA_W-1:0] imp_ring  [CELLS][DEPTH];
    int unsigned              next_slot [CELLS];
    int unsigned              fill      [CELLS];
    longint                   volt_sum  [CELLS];
    longint                   imp_sum   [CELLS];
    average_t                 expected_averages [$];
    average_t                 want;

    function automatic average_t advance_cell_average(
        logic [CELL_W-1:0]        cell_id,
        logic signed [DATA_W-1:0] volt,
        logic signed [DATA_W-1:0] imp
    );
        average_t    avg;
        int unsigned c;
        int unsigned slot;
        avg.cell_id = cell_id;
        avg.volt    = '0;
        avg.imp     = '0;
        c = 32'(cell_id);
        if (c < CELLS)
        begin
            slot = next_slot[c];
            // Once the ring is full, the oldest sample leaves the sum first.
            if (fill[c] == DEPTH)
            begin
                volt_sum[c] -= longint'(volt_ring[c][slot]);
                imp_sum[c]  -= longint'(imp_ring[c][slot]);
            end
            else
            begin
                fill[c]++;
            end
            volt_ring[c][slot] = volt;
            imp_ring[c][slot]  = imp;
            volt_sum[c] += longint'(volt);
            imp_sum[c]  += longint'(imp);
            next_slot[c] = (slot + 1) % DEPTH;
            avg.volt = DATA_W'(volt_sum[c] / longint'(fill[c]));
            avg.imp  = DATA_W'(imp_sum[c] / longint'(fill[c]));
        end
        return avg;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CELLS; c++)
            begin
                next_slot[c] = 0;
                fill[c]      = 0;
                volt_sum[c]  = 0;
                imp_sum[c]   = 0;
            end
            expected_averages.delete();
            mismatches       <= 0;
            averages_checked <= 0;
            outstanding      <= 0;
        end
        else
        begin
            if (sample_valid && sample_ready)
            begin
                expected_averages.push_back(
                    advance_cell_average(cell_index, voltage_sample, impedance_sample));
            end
            if (average_valid && average_ready)
            begin
                if (expected_averages.size() == 0)
                begin
                    $display("%0t: average transaction with none expected, cell %0d",
                             $time, cell_out);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_averages.pop_front();
                    averages_checked <= averages_checked + 1;
                    if (cell_out !== want.cell_id || voltage_average !== want.volt ||
                        impedance_average !== want.imp)
                    begin
                        mismatches <= mismatches + 1;
                    end
                    if (cell_out !== want.cell_id)
                    begin
                        $display("%0t: cell_out expected %0d, actual %0d",
                                 $time, want.cell_id, cell_out);
                    end
                    if (voltage_average !== want.volt)
                    begin
                        $display("%0t: voltage_average of cell %0d expected %0d, actual %0d",
                                 $time, want.cell_id, want.volt, voltage_average);
                    end
                    if (impedance_average !== want.imp)
                    begin
                        $display("%0t: impedance_average of cell %0d expected %0d, actual %0d",
                                 $time, want.cell_id, want.imp, impedance_average);
                    end
                end
            end
            outstanding <= expected_averages.size();
        end
    end

endmodule

// ===== verif/per_cell_moving_average_tb.sv =====
// Top of the per-cell moving average testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module per_cell_moving_average_tb;
    import pcma_pkg::*;

    localparam int PHASES          = 4;
    localparam int ITEMS_PER_PHASE = 460;
    localparam int MAX_IDLE        = 12;
    localparam int LONG_HOLD       = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 8;

    localparam logic signed [DATA_W-1:0] SAMPLE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAMPLE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [CELL_W-1:0]        LAST_CELL  = {CELL_W{1'b1}};

    logic                     clk               = 1'b0;
    logic                     rst_n             = 1'b0;
    logic                     sample_valid      = 1'b0;
    logic                     sample_ready;
    logic [CELL_W-1:0]        cell_index        = '0;
    logic signed [DATA_W-1:0] voltage_sample    = '0;
    logic signed [DATA_W-1:0] impedance_sample  = '0;
    logic                     average_valid;
    logic                     average_ready     = 1'b0;
    logic [CELL_W-1:0]        cell_out;
    logic signed [DATA_W-1:0] voltage_average;
    logic signed [DATA_W-1:0] impedance_average;

    int mismatches;
    int outstanding;
    int averages_checked;
    int samples_sent      = 0;
    int quiet_cycles      = 0;
    bit sender_idle       = 1'b1;
    bit receiver_idle     = 1'b1;
    bit long_hold_request = 1'b0;
    bit long_hold_done    = 1'b0;

    per_cell_moving_average u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .sample_valid      (sample_valid),
        .sample_ready      (sample_ready),
        .cell_index        (cell_index),
        .voltage_sample    (voltage_sample),
        .impedance_sample  (impedance_sample),
        .average_valid     (average_valid),
        .average_ready     (average_ready),
        .cell_out          (cell_out),
        .voltage_average   (voltage_average),
        .impedance_average (impedance_average)
    );

    pcma_average_checker u_average_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .sample_valid      (sample_valid),
        .sample_ready      (sample_ready),
        .cell_index        (cell_index),
        .voltage_sample    (voltage_sample),
        .impedance_sample  (impedance_sample),
        .average_valid     (average_valid),
        .average_ready     (average_ready),
        .cell_out          (cell_out),
        .voltage_average   (voltage_average),
        .impedance_average (impedance_average),
        .mismatches        (mismatches),
        .outstanding       (outstanding),
        .averages_checked  (averages_checked)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic signed [DATA_W-1:0] draw_sample();
        unique case ($urandom_range(0, 7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return DATA_W'($urandom_range(0, 16)) - DATA_W'(8);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the transaction is accepted.
    task automatic send_sample(
        input logic [CELL_W-1:0]        cell_id,
        input logic signed [DATA_W-1:0] volt,
        input logic signed [DATA_W-1:0] imp
    );
        int gap;
        gap = sender_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid     <= 1'b1;
        cell_index       <= cell_id;
        voltage_sample   <= volt;
        impedance_sample <= imp;
        do @(posedge clk); while (!sample_ready);
        samples_sent++;
    endtask

    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_request && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                average_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = receiver_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (gap > 0)
            begin
                average_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            average_ready <= 1'b1;
            do @(posedge clk); while (!average_valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && sample_ready) || (average_valid && average_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        logic [CELL_W-1:0] cell_id;
        int                directed;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Warm-up to a full ring at both extremes, then wrap with the opposite extremes.
        repeat (4) send_sample('0, SAMPLE_MAX, SAMPLE_MIN);
        repeat (2) send_sample('0, SAMPLE_MIN, SAMPLE_MAX);
        // Small mixed-sign values show truncation toward zero in both directions.
        send_sample(LAST_CELL, DATA_W'(-1), DATA_W'(1));
        send_sample(LAST_CELL, DATA_W'(-2), DATA_W'(2));
        send_sample(LAST_CELL, DATA_W'(1), DATA_W'(-1));
        send_sample(LAST_CELL, SAMPLE_MIN, SAMPLE_MAX);
        send_sample(LAST_CELL, DATA_W'(5), DATA_W'(-7));
        send_sample(LAST_CELL, DATA_W'(3), DATA_W'(-3));
        for (int c = 1; c <= 4; c++)
        begin
            send_sample(CELL_W'(c), SAMPLE_MAX, SAMPLE_MAX);
            send_sample(CELL_W'(c), SAMPLE_MIN, SAMPLE_MIN);
        end
        send_sample(CELL_W'(17), '0, '0);
        send_sample(CELL_W'(17), DATA_W'(7), DATA_W'(-7));
        directed = samples_sent;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            sender_idle   = (phase == 0) || (phase == 2);
            receiver_idle = (phase == 0) || (phase == 3);
            if (phase == 1)
            begin
                long_hold_request = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Most samples go to a few cells so their rings wrap many times.
                if ($urandom_range(0, 9) < 7)
                begin
                    cell_id = CELL_W'($urandom_range(0, 3));
                end
                else
                begin
                    cell_id = CELL_W'($urandom);
                end
                send_sample(cell_id, draw_sample(), draw_sample());
            end
        end
        sample_valid <= 1'b0;

        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: %0d sample transactions (%0d directed) under four idle patterns,",
                 samples_sent, directed);
        $display("one long output stall; %0d averages compared, %0d mismatches, %0d left over.",
                 averages_checked, mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
